@@ hw/rtl/wds_pkg.sv @@
// shared types and constants of the wilson-dirac site block
package wds_pkg;

	localparam int SPIN_W = 64;
	localparam int LINK_W = 32;
	localparam int Q_W    = 16;
	localparam int NDIR   = 4;
	localparam int NCOMP  = 4;
	localparam int C_W    = 18;
	localparam int PROD_W = Q_W + C_W + 1;
	localparam int MASS_W = Q_W + 1;
	localparam int MV_W   = MASS_W + Q_W;
	localparam int TOT_W  = 40;
	localparam int RND_SH = 15;

	localparam logic signed [MASS_W-1:0] MASS_OFFSET = 17'sd8192;
	localparam logic signed [TOT_W-1:0]  RND_HALF    = 40'sd16384;
	localparam logic signed [Q_W-1:0]    Q_MAX       = 16'sh7fff;
	localparam logic signed [Q_W-1:0]    Q_MIN       = 16'sh8000;

	typedef enum logic [1:0] {
		DIR_RX = 2'd0,
		DIR_RT = 2'd1,
		DIR_LX = 2'd2,
		DIR_LT = 2'd3
	} dir_e;

	typedef struct packed {
		logic neg;
		logic live;
	} nbr_ctl_t;

endpackage

@@ hw/rtl/wds_if.sv @@
// handshake interfaces for site words, result words and the mass register
interface wds_site_if;
	logic                          valid;
	logic                          ready;
	logic [wds_pkg::SPIN_W-1:0]    center_spinor;
	logic [wds_pkg::SPIN_W-1:0]    right_x_spinor;
	logic [wds_pkg::SPIN_W-1:0]    right_t_spinor;
	logic [wds_pkg::SPIN_W-1:0]    left_x_spinor;
	logic [wds_pkg::SPIN_W-1:0]    left_t_spinor;
	logic [wds_pkg::LINK_W-1:0]    link_fwd_x;
	logic [wds_pkg::LINK_W-1:0]    link_fwd_t;
	logic [wds_pkg::LINK_W-1:0]    link_back_x;
	logic [wds_pkg::LINK_W-1:0]    link_back_t;
	logic [wds_pkg::NDIR-1:0]      boundary_signs;
	logic [wds_pkg::NDIR-1:0]      in_block_mask;

	modport source (
		output valid, center_spinor, right_x_spinor, right_t_spinor, left_x_spinor,
		       left_t_spinor, link_fwd_x, link_fwd_t, link_back_x, link_back_t,
		       boundary_signs, in_block_mask,
		input  ready
	);
	modport sink (
		input  valid, center_spinor, right_x_spinor, right_t_spinor, left_x_spinor,
		       left_t_spinor, link_fwd_x, link_fwd_t, link_back_x, link_back_t,
		       boundary_signs, in_block_mask,
		output ready
	);
endinterface

interface wds_result_if;
	logic                          valid;
	logic                          ready;
	logic signed [wds_pkg::Q_W-1:0] upper_re;
	logic signed [wds_pkg::Q_W-1:0] upper_im;
	logic signed [wds_pkg::Q_W-1:0] lower_re;
	logic signed [wds_pkg::Q_W-1:0] lower_im;
	logic                          saturated;

	modport source (
		output valid, upper_re, upper_im, lower_re, lower_im, saturated,
		input  ready
	);
	modport sink (
		input  valid, upper_re, upper_im, lower_re, lower_im, saturated,
		output ready
	);
endinterface

interface wds_cfg_if;
	logic                          valid;
	logic                          ready;
	logic signed [wds_pkg::Q_W-1:0] bare_mass;

	modport source (output valid, bare_mass, input ready);
	modport sink (input valid, bare_mass, output ready);
endinterface

@@ hw/rtl/wds_link_mul.sv @@
// one neighbour hopping term: spin projection, sign and mask, then link multiply
module wds_link_mul (
	input  wds_pkg::dir_e                      dir,
	input  wds_pkg::nbr_ctl_t                  ctl,
	input  logic [wds_pkg::SPIN_W-1:0]         spinor,
	input  logic [wds_pkg::LINK_W-1:0]         link,
	output logic signed [wds_pkg::PROD_W-1:0]  w_re,
	output logic signed [wds_pkg::PROD_W-1:0]  w_im
);

	logic signed [wds_pkg::C_W-1:0]      p0_re, p0_im, p1_re, p1_im;
	logic signed [wds_pkg::C_W-1:0]      c_re, c_im, cs_re, cs_im;
	logic signed [wds_pkg::Q_W-1:0]      u_re, u_im;
	logic signed [wds_pkg::PROD_W-1:0]   rr, ii, ri, ir;
	logic                                conj;

	assign p0_re = wds_pkg::C_W'($signed(spinor[15:0]));
	assign p0_im = wds_pkg::C_W'($signed(spinor[31:16]));
	assign p1_re = wds_pkg::C_W'($signed(spinor[47:32]));
	assign p1_im = wds_pkg::C_W'($signed(spinor[63:48]));
	assign u_re  = $signed(link[15:0]);
	assign u_im  = $signed(link[31:16]);

	always_comb begin
		conj = 1'b0;
		case (dir)
			wds_pkg::DIR_RX: begin
				c_re = p0_re - p1_re;
				c_im = p0_im - p1_im;
			end
			wds_pkg::DIR_RT: begin
				c_re = p0_re - p1_im;
				c_im = p0_im + p1_re;
			end
			wds_pkg::DIR_LX: begin
				c_re = p0_re + p1_re;
				c_im = p0_im + p1_im;
				conj = 1'b1;
			end
			wds_pkg::DIR_LT: begin
				c_re = p0_re + p1_im;
				c_im = p0_im - p1_re;
				conj = 1'b1;
			end
			default: begin
				c_re = '0;
				c_im = '0;
			end
		endcase
	end

	// outside the block counts as zero, boundary sign folds into the spinor
	always_comb begin
		if (!ctl.live) begin
			cs_re = '0;
			cs_im = '0;
		end else if (ctl.neg) begin
			cs_re = -c_re;
			cs_im = -c_im;
		end else begin
			cs_re = c_re;
			cs_im = c_im;
		end
	end

	assign rr = wds_pkg::PROD_W'(u_re) * wds_pkg::PROD_W'(cs_re);
	assign ii = wds_pkg::PROD_W'(u_im) * wds_pkg::PROD_W'(cs_im);
	assign ri = wds_pkg::PROD_W'(u_re) * wds_pkg::PROD_W'(cs_im);
	assign ir = wds_pkg::PROD_W'(u_im) * wds_pkg::PROD_W'(cs_re);

	assign w_re = conj ? (rr + ii) : (rr - ii);
	assign w_im = conj ? (ri - ir) : (ri + ir);

endmodule

@@ hw/rtl/wds_round_sat.sv @@
// round 27 fraction bits to q3.12 half up and clip to 16 bits
module wds_round_sat (
	input  logic signed [wds_pkg::TOT_W-1:0] total,
	output logic signed [wds_pkg::Q_W-1:0]   value,
	output logic                             clip
);

	localparam int R_W = wds_pkg::TOT_W - wds_pkg::RND_SH;

	logic signed [wds_pkg::TOT_W-1:0] biased;
	logic signed [R_W-1:0]            r;

	assign biased = total + wds_pkg::RND_HALF;
	assign r      = biased[wds_pkg::TOT_W-1:wds_pkg::RND_SH];

	// clipped when the bits above the 16-bit result are not all sign copies
	assign clip = !((&r[R_W-1:wds_pkg::Q_W-1]) || !(|r[R_W-1:wds_pkg::Q_W-1]));

	always_comb begin
		if (!clip) begin
			value = r[wds_pkg::Q_W-1:0];
		end else if (r[R_W-1]) begin
			value = wds_pkg::Q_MIN;
		end else begin
			value = wds_pkg::Q_MAX;
		end
	end

endmodule

@@ hw/rtl/block_wilson_dirac_site.sv @@
// wilson-dirac site: top level with input, product and result registers
// the site word passes three register stages: input, product and result
// throughput: one site word per cycle unless result.ready stalls the stages, set by the single product stage
// 20 multipliers (16 link, 4 mass) work in parallel on each word
// arst_n clears all valid flags and bare_mass to zero; no clearing pass
module block_wilson_dirac_site (
	input  logic        clk,
	input  logic        arst_n,
	wds_site_if.sink    site,
	wds_cfg_if.sink     cfg,
	wds_result_if.source result
);

	logic                                   v_s1, v_s2, res_valid_q;
	logic                                   en1, en2, en3;
	logic signed [wds_pkg::Q_W-1:0]         bare_mass_q;

	logic [wds_pkg::SPIN_W-1:0]             center_s1;
	logic [wds_pkg::SPIN_W-1:0]             nbr_s1 [wds_pkg::NDIR];
	logic [wds_pkg::LINK_W-1:0]             link_s1 [wds_pkg::NDIR];
	logic [wds_pkg::NDIR-1:0]               signs_s1, mask_s1;

	logic signed [wds_pkg::PROD_W-1:0]      w_re_d [wds_pkg::NDIR];
	logic signed [wds_pkg::PROD_W-1:0]      w_im_d [wds_pkg::NDIR];
	logic signed [wds_pkg::PROD_W-1:0]      w_re_s2 [wds_pkg::NDIR];
	logic signed [wds_pkg::PROD_W-1:0]      w_im_s2 [wds_pkg::NDIR];
	logic signed [wds_pkg::MASS_W-1:0]      mass_f;
	logic signed [wds_pkg::MV_W-1:0]        mv_d [wds_pkg::NCOMP];
	logic signed [wds_pkg::MV_W-1:0]        mv_s2 [wds_pkg::NCOMP];

	logic signed [wds_pkg::TOT_W-1:0]       hop [wds_pkg::NCOMP];
	logic signed [wds_pkg::TOT_W-1:0]       tot [wds_pkg::NCOMP];
	logic signed [wds_pkg::Q_W-1:0]         val [wds_pkg::NCOMP];
	logic [wds_pkg::NCOMP-1:0]              clip;

	// stage enables, each stage moves when its slot is free or drains
	assign en3        = !res_valid_q || result.ready;
	assign en2        = !v_s2 || en3;
	assign en1        = !v_s1 || en2;
	assign site.ready = en1;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
			bare_mass_q <= '0;
		end else begin
			if (en1) v_s1 <= site.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) res_valid_q <= v_s2;
			if (cfg.valid) bare_mass_q <= cfg.bare_mass;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (en1 && site.valid) begin
			center_s1  <= site.center_spinor;
			nbr_s1[0]  <= site.right_x_spinor;
			nbr_s1[1]  <= site.right_t_spinor;
			nbr_s1[2]  <= site.left_x_spinor;
			nbr_s1[3]  <= site.left_t_spinor;
			link_s1[0] <= site.link_fwd_x;
			link_s1[1] <= site.link_fwd_t;
			link_s1[2] <= site.link_back_x;
			link_s1[3] <= site.link_back_t;
			signs_s1   <= site.boundary_signs;
			mask_s1    <= site.in_block_mask;
		end
	end

	for (genvar d = 0; d < wds_pkg::NDIR; d++) begin : g_dir
		wds_pkg::nbr_ctl_t ctl;
		assign ctl.neg  = signs_s1[d];
		assign ctl.live = mask_s1[d];

		wds_link_mul u_mul (
			.dir    (wds_pkg::dir_e'(2'(d))),
			.ctl    (ctl),
			.spinor (nbr_s1[d]),
			.link   (link_s1[d]),
			.w_re   (w_re_d[d]),
			.w_im   (w_im_d[d])
		);
	end

	assign mass_f = wds_pkg::MASS_W'(bare_mass_q) + wds_pkg::MASS_OFFSET;

	for (genvar k = 0; k < wds_pkg::NCOMP; k++) begin : g_mass
		assign mv_d[k] = wds_pkg::MV_W'(mass_f)
		               * wds_pkg::MV_W'($signed(center_s1[16*k +: 16]));
	end

	// product register
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			w_re_s2 <= w_re_d;
			w_im_s2 <= w_im_d;
			mv_s2   <= mv_d;
		end
	end

	// upper takes the plain sum, lower takes it rotated by -1, -i, 1, i
	assign hop[0] = wds_pkg::TOT_W'(w_re_s2[0]) + wds_pkg::TOT_W'(w_re_s2[1])
	              + wds_pkg::TOT_W'(w_re_s2[2]) + wds_pkg::TOT_W'(w_re_s2[3]);
	assign hop[1] = wds_pkg::TOT_W'(w_im_s2[0]) + wds_pkg::TOT_W'(w_im_s2[1])
	              + wds_pkg::TOT_W'(w_im_s2[2]) + wds_pkg::TOT_W'(w_im_s2[3]);
	assign hop[2] = wds_pkg::TOT_W'(w_im_s2[1]) - wds_pkg::TOT_W'(w_re_s2[0])
	              + wds_pkg::TOT_W'(w_re_s2[2]) - wds_pkg::TOT_W'(w_im_s2[3]);
	assign hop[3] = wds_pkg::TOT_W'(w_im_s2[2]) - wds_pkg::TOT_W'(w_im_s2[0])
	              - wds_pkg::TOT_W'(w_re_s2[1]) + wds_pkg::TOT_W'(w_re_s2[3]);

	for (genvar k = 0; k < wds_pkg::NCOMP; k++) begin : g_fin
		assign tot[k] = (wds_pkg::TOT_W'(mv_s2[k]) <<< 3) - hop[k];

		wds_round_sat u_rs (
			.total (tot[k]),
			.value (val[k]),
			.clip  (clip[k])
		);
	end

	// result register
	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			result.upper_re  <= val[0];
			result.upper_im  <= val[1];
			result.lower_re  <= val[2];
			result.lower_im  <= val[3];
			result.saturated <= |clip;
		end
	end

	assign result.valid = res_valid_q;

`ifndef ASSERT_OFF
	a_accept_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		site.valid && site.ready |=> v_s1)
		else $error("accepted site word missing from input stage");

	a_s2_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && en3 |=> res_valid_q)
		else $error("product stage word lost before result register");

	a_mass_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.valid |=> $stable(bare_mass_q))
		else $error("bare mass changed without a write");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.saturated |->
			result.upper_re == wds_pkg::Q_MAX || result.upper_re == wds_pkg::Q_MIN ||
			result.upper_im == wds_pkg::Q_MAX || result.upper_im == wds_pkg::Q_MIN ||
			result.lower_re == wds_pkg::Q_MAX || result.lower_re == wds_pkg::Q_MIN ||
			result.lower_im == wds_pkg::Q_MAX || result.lower_im == wds_pkg::Q_MIN)
		else $error("saturated word without a clipped component");
`endif

endmodule
